FILE: hw/rtl/quaternion_to_rotation_matrix_macros.svh
// Assertion macros for the checker file qrm_checker.sv.
`ifndef QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define QRM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quaternion_to_rotation_matrix: implication failed");

// Antecedent implies consequent after the delay given by dly.
`define QRM_ASSERT_DELAY(label, clk, rst, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("quaternion_to_rotation_matrix: delayed implication failed");

`endif

FILE: hw/rtl/qrm_pkg.sv
// Shared types and constants for the quaternion to rotation matrix pipeline.
package qrm_pkg;

  localparam int unsigned NUM_ENTRIES  = 9;
  localparam int unsigned NUM_PRODUCTS = 10;

  // product slots
  localparam int unsigned P_XX = 0;
  localparam int unsigned P_YY = 1;
  localparam int unsigned P_ZZ = 2;
  localparam int unsigned P_WW = 3;
  localparam int unsigned P_XY = 4;
  localparam int unsigned P_XZ = 5;
  localparam int unsigned P_YZ = 6;
  localparam int unsigned P_WX = 7;
  localparam int unsigned P_WY = 8;
  localparam int unsigned P_WZ = 9;

  typedef struct packed {
    logic valid;
    logic degen;
  } qrm_ctl_t;

endpackage

FILE: hw/rtl/qrm_products.sv
// Input register, zero detect and the ten component products.
module qrm_products #(
  parameter int COMPONENT_WIDTH = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req,
  input  logic signed [COMPONENT_WIDTH-1:0] x,
  input  logic signed [COMPONENT_WIDTH-1:0] y,
  input  logic signed [COMPONENT_WIDTH-1:0] z,
  input  logic signed [COMPONENT_WIDTH-1:0] w,
  output qrm_pkg::qrm_ctl_t                 ctl_o,
  output logic signed [2*COMPONENT_WIDTH-1:0] prod [qrm_pkg::NUM_PRODUCTS]
);
  localparam int PW = 2 * COMPONENT_WIDTH;

  logic                              vld1;
  logic signed [COMPONENT_WIDTH-1:0] x1, y1, z1, w1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= req;
    end
    x1 <= x;
    y1 <= y;
    z1 <= z;
    w1 <= w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o.valid <= vld1;
      ctl_o.degen <= (x1 == '0) && (y1 == '0) && (z1 == '0) && (w1 == '0);
    end
    prod[qrm_pkg::P_XX] <= PW'(x1) * PW'(x1);
    prod[qrm_pkg::P_YY] <= PW'(y1) * PW'(y1);
    prod[qrm_pkg::P_ZZ] <= PW'(z1) * PW'(z1);
    prod[qrm_pkg::P_WW] <= PW'(w1) * PW'(w1);
    prod[qrm_pkg::P_XY] <= PW'(x1) * PW'(y1);
    prod[qrm_pkg::P_XZ] <= PW'(x1) * PW'(z1);
    prod[qrm_pkg::P_YZ] <= PW'(y1) * PW'(z1);
    prod[qrm_pkg::P_WX] <= PW'(w1) * PW'(x1);
    prod[qrm_pkg::P_WY] <= PW'(w1) * PW'(y1);
    prod[qrm_pkg::P_WZ] <= PW'(w1) * PW'(z1);
  end
endmodule

FILE: hw/rtl/qrm_sums.sv
// Squared norm and entry numerators, then sign and magnitude split.
module qrm_sums #(
  parameter int COMPONENT_WIDTH = 18
) (
  input  logic                                clk,
  input  logic                                rst,
  input  qrm_pkg::qrm_ctl_t                   ctl_i,
  input  logic signed [2*COMPONENT_WIDTH-1:0] prod [qrm_pkg::NUM_PRODUCTS],
  output qrm_pkg::qrm_ctl_t                   ctl_o,
  output logic [2*COMPONENT_WIDTH+1:0]        norm,
  output logic [2*COMPONENT_WIDTH+1:0]        mag [qrm_pkg::NUM_ENTRIES],
  output logic                                neg [qrm_pkg::NUM_ENTRIES]
);
  localparam int NW = 2 * COMPONENT_WIDTH + 2;

  qrm_pkg::qrm_ctl_t    ctl_a;
  logic signed [NW-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;
  logic signed [NW-1:0] num_next [qrm_pkg::NUM_ENTRIES];
  logic signed [NW-1:0] num [qrm_pkg::NUM_ENTRIES];
  logic [NW-1:0]        norm3;

  // every numerator magnitude is bounded by the norm, so NW bits never overflow
  always_comb begin
    xx = NW'(prod[qrm_pkg::P_XX]);
    yy = NW'(prod[qrm_pkg::P_YY]);
    zz = NW'(prod[qrm_pkg::P_ZZ]);
    ww = NW'(prod[qrm_pkg::P_WW]);
    xy = NW'(prod[qrm_pkg::P_XY]);
    xz = NW'(prod[qrm_pkg::P_XZ]);
    yz = NW'(prod[qrm_pkg::P_YZ]);
    wx = NW'(prod[qrm_pkg::P_WX]);
    wy = NW'(prod[qrm_pkg::P_WY]);
    wz = NW'(prod[qrm_pkg::P_WZ]);
    num_next[0] = xx + ww - yy - zz;
    num_next[1] = (xy - wz) <<< 1;
    num_next[2] = (xz + wy) <<< 1;
    num_next[3] = (xy + wz) <<< 1;
    num_next[4] = yy + ww - xx - zz;
    num_next[5] = (yz - wx) <<< 1;
    num_next[6] = (xz - wy) <<< 1;
    num_next[7] = (yz + wx) <<< 1;
    num_next[8] = zz + ww - xx - yy;
  end

  // stage A: norm and signed numerators
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else begin
      ctl_a <= ctl_i;
    end
    norm3 <= $unsigned(xx + yy + zz + ww);
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      num[i] <= num_next[i];
    end
  end

  // stage B: sign and magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_a;
    end
    norm <= norm3;
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      neg[i] <= num[i][NW-1];
      mag[i] <= num[i][NW-1] ? $unsigned(-num[i]) : $unsigned(num[i]);
    end
  end
endmodule

FILE: hw/rtl/qrm_div_stage.sv
// One restoring division step for all nine entries.
module qrm_div_stage #(
  parameter int COMPONENT_WIDTH = 18,
  parameter bit SHIFT           = 1'b1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qrm_pkg::qrm_ctl_t            ctl_i,
  input  logic [2*COMPONENT_WIDTH+1:0] norm_i,
  input  logic [2*COMPONENT_WIDTH+1:0] rem_i [qrm_pkg::NUM_ENTRIES],
  input  logic [COMPONENT_WIDTH-1:0]   q_i   [qrm_pkg::NUM_ENTRIES],
  input  logic                         neg_i [qrm_pkg::NUM_ENTRIES],
  output qrm_pkg::qrm_ctl_t            ctl_o,
  output logic [2*COMPONENT_WIDTH+1:0] norm_o,
  output logic [2*COMPONENT_WIDTH+1:0] rem_o [qrm_pkg::NUM_ENTRIES],
  output logic [COMPONENT_WIDTH-1:0]   q_o   [qrm_pkg::NUM_ENTRIES],
  output logic                         neg_o [qrm_pkg::NUM_ENTRIES]
);
  localparam int NW = 2 * COMPONENT_WIDTH + 2;

  logic [NW-1:0] rem_s [qrm_pkg::NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      rem_s[i] = SHIFT ? {rem_i[i][NW-2:0], 1'b0} : rem_i[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
    norm_o <= norm_i;
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      neg_o[i] <= neg_i[i];
      if (rem_s[i] >= norm_i) begin
        rem_o[i] <= rem_s[i] - norm_i;
        q_o[i]   <= {q_i[i][COMPONENT_WIDTH-2:0], 1'b1};
      end else begin
        rem_o[i] <= rem_s[i];
        q_o[i]   <= {q_i[i][COMPONENT_WIDTH-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: hw/rtl/qrm_round.sv
// Round half away from zero, apply sign, identity override for zero input.
module qrm_round #(
  parameter int COMPONENT_WIDTH = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  qrm_pkg::qrm_ctl_t                 ctl_i,
  input  logic [COMPONENT_WIDTH-1:0]        q_i   [qrm_pkg::NUM_ENTRIES],
  input  logic                              neg_i [qrm_pkg::NUM_ENTRIES],
  output qrm_pkg::qrm_ctl_t                 ctl_o,
  output logic signed [COMPONENT_WIDTH-1:0] ent   [qrm_pkg::NUM_ENTRIES]
);
  localparam int W = COMPONENT_WIDTH;
  localparam logic [W-1:0] ONE = W'(1) << (W - 2);

  logic [W:0]   qr_sum [qrm_pkg::NUM_ENTRIES];
  logic [W-1:0] qr     [qrm_pkg::NUM_ENTRIES];

  always_comb begin
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      qr_sum[i] = {1'b0, q_i[i]} + (W + 1)'(1);
      qr[i]     = qr_sum[i][W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      if (ctl_i.degen) begin
        ent[i] <= (i % 4 == 0) ? ONE : '0;
      end else begin
        ent[i] <= neg_i[i] ? -qr[i] : qr[i];
      end
    end
  end
endmodule

FILE: hw/rtl/quaternion_to_rotation_matrix.sv
// Quaternion to 3x3 rotation matrix: top level of the streaming pipeline.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   busy is held low: the pipeline takes one quaternion every cycle.
//   quat_x/y/z/w are signed fixed point with COMPONENT_WIDTH-2 fraction bits
//   (Q2.16 at the default width); the quaternion need not be unit length.
//   Each result shows on r00..r22 and degenerate for exactly one cycle with
//   done high. Entries use the same format, rounded half away from zero.
//   A zero quaternion gives the identity matrix and degenerate = 1.
// Throughput: 1 per cycle. The divider does one restoring step per stage,
//   nine lanes side by side, COMPONENT_WIDTH stages deep, all sharing the
//   norm.
// Stages: input reg, ten products, norm and numerators, sign/magnitude,
//   division steps, round and sign.
// Reset: clears the valid bits of every stage; in-flight requests are lost.
// The receiver cannot stall: results appear whether or not anyone looks.
module quaternion_to_rotation_matrix #(
  parameter int COMPONENT_WIDTH = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  output logic                              done,
  output logic signed [COMPONENT_WIDTH-1:0] r00,
  output logic signed [COMPONENT_WIDTH-1:0] r01,
  output logic signed [COMPONENT_WIDTH-1:0] r02,
  output logic signed [COMPONENT_WIDTH-1:0] r10,
  output logic signed [COMPONENT_WIDTH-1:0] r11,
  output logic signed [COMPONENT_WIDTH-1:0] r12,
  output logic signed [COMPONENT_WIDTH-1:0] r20,
  output logic signed [COMPONENT_WIDTH-1:0] r21,
  output logic signed [COMPONENT_WIDTH-1:0] r22,
  output logic                              degenerate
);
  localparam int W       = COMPONENT_WIDTH;
  localparam int NW      = 2 * W + 2;
  // first step compares without shift, then W-1 shift-and-compare steps
  localparam int NSTG    = W;
  localparam int LATENCY = W + 5;

  qrm_pkg::qrm_ctl_t          ctl_p, ctl_s, ctl_r;
  logic signed [2*W-1:0]      prod [qrm_pkg::NUM_PRODUCTS];
  logic signed [W-1:0]        ent  [qrm_pkg::NUM_ENTRIES];

  qrm_pkg::qrm_ctl_t ctl_d  [NSTG+1];
  logic [NW-1:0]     norm_d [NSTG+1];
  logic [NW-1:0]     rem_d  [NSTG+1][qrm_pkg::NUM_ENTRIES];
  logic [W-1:0]      q_d    [NSTG+1][qrm_pkg::NUM_ENTRIES];
  logic              neg_d  [NSTG+1][qrm_pkg::NUM_ENTRIES];

  // no back-pressure anywhere in the pipe
  assign busy = 1'b0;

  qrm_products #(.COMPONENT_WIDTH(W)) u_prod (
    .clk   (clk),
    .rst   (rst),
    .req   (start),
    .x     (quat_x),
    .y     (quat_y),
    .z     (quat_z),
    .w     (quat_w),
    .ctl_o (ctl_p),
    .prod  (prod)
  );

  qrm_sums #(.COMPONENT_WIDTH(W)) u_sums (
    .clk   (clk),
    .rst   (rst),
    .ctl_i (ctl_p),
    .prod  (prod),
    .ctl_o (ctl_s),
    .norm  (norm_d[0]),
    .mag   (rem_d[0]),
    .neg   (neg_d[0])
  );

  assign ctl_d[0] = ctl_s;

  always_comb begin
    for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++) begin
      q_d[0][i] = '0;
    end
  end

  // quotient of mag * 2^(W-1) / norm, one bit per stage
  for (genvar s = 0; s < NSTG; s++) begin : g_div
    qrm_div_stage #(
      .COMPONENT_WIDTH (W),
      .SHIFT           ((s == 0) ? 1'b0 : 1'b1)
    ) u_stage (
      .clk    (clk),
      .rst    (rst),
      .ctl_i  (ctl_d[s]),
      .norm_i (norm_d[s]),
      .rem_i  (rem_d[s]),
      .q_i    (q_d[s]),
      .neg_i  (neg_d[s]),
      .ctl_o  (ctl_d[s+1]),
      .norm_o (norm_d[s+1]),
      .rem_o  (rem_d[s+1]),
      .q_o    (q_d[s+1]),
      .neg_o  (neg_d[s+1])
    );
  end

  qrm_round #(.COMPONENT_WIDTH(W)) u_round (
    .clk   (clk),
    .rst   (rst),
    .ctl_i (ctl_d[NSTG]),
    .q_i   (q_d[NSTG]),
    .neg_i (neg_d[NSTG]),
    .ctl_o (ctl_r),
    .ent   (ent)
  );

  assign done       = ctl_r.valid;
  assign degenerate = ctl_r.degen;
  assign r00 = ent[0];
  assign r01 = ent[1];
  assign r02 = ent[2];
  assign r10 = ent[3];
  assign r11 = ent[4];
  assign r12 = ent[5];
  assign r20 = ent[6];
  assign r21 = ent[7];
  assign r22 = ent[8];
endmodule

FILE: hw/rtl/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix block, with bind.
`include "quaternion_to_rotation_matrix_macros.svh"

module qrm_checker #(
  parameter int COMPONENT_WIDTH = 18,
  parameter int LATENCY         = 23
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [COMPONENT_WIDTH-1:0] r00,
  input logic signed [COMPONENT_WIDTH-1:0] r01,
  input logic signed [COMPONENT_WIDTH-1:0] r11,
  input logic signed [COMPONENT_WIDTH-1:0] r22,
  input logic                              degenerate
);
  localparam logic signed [COMPONENT_WIDTH-1:0] ONE =
    COMPONENT_WIDTH'(1) << (COMPONENT_WIDTH - 2);

  `QRM_ASSERT_DELAY(a_req_gives_result, clk, rst, start && !busy, LATENCY, done)
  `QRM_ASSERT_IMPL(a_result_had_req, clk, rst, done, $past(start && !busy, LATENCY))
  `QRM_ASSERT_IMPL(a_degen_identity, clk, rst, done && degenerate,
                   r00 == ONE && r11 == ONE && r22 == ONE && r01 == '0)
  `QRM_ASSERT_IMPL(a_diag_bounded, clk, rst, done,
                   r00 <= ONE && r00 >= -ONE && r11 <= ONE && r11 >= -ONE)
endmodule

bind quaternion_to_rotation_matrix qrm_checker #(
  .COMPONENT_WIDTH (COMPONENT_WIDTH),
  .LATENCY         (LATENCY)
) u_qrm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .r00        (r00),
  .r01        (r01),
  .r11        (r11),
  .r22        (r22),
  .degenerate (degenerate)
);

FILE: tb/quaternion_to_rotation_matrix_tb.sv
// Self-checking testbench for the quaternion to rotation matrix pipeline.
module quaternion_to_rotation_matrix_tb;

  localparam int CW = 18;
  localparam int FB = CW - 2;
  localparam int LATENCY = CW + 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 1830;

  typedef logic signed [CW-1:0] comp_t;

  // One matrix result as the block reports it.
  typedef struct {
    comp_t m[9];
    logic  degen;
  } matrix_t;

  // Exact ratio num * 2^FB / n, rounded half away from zero, saturated.
  function automatic comp_t ratio_to_entry(longint num, longint n);
    longint mag, q, val;
    bit neg;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= 2 * n) begin
      val = neg ? -(longint'(1) << (CW - 1)) : (longint'(1) << (CW - 1)) - 1;
      return comp_t'(val);
    end
    // mag < 2n < 2^38, so mag << (FB+1) stays under 2^55
    q = ((mag << (FB + 1)) / n + 1) >>> 1;
    val = neg ? -q : q;
    if (val > (longint'(1) << (CW - 1)) - 1) val = (longint'(1) << (CW - 1)) - 1;
    if (val < -(longint'(1) << (CW - 1))) val = -(longint'(1) << (CW - 1));
    return comp_t'(val);
  endfunction

  function automatic matrix_t rotation_of(comp_t qx, comp_t qy, comp_t qz, comp_t qw);
    matrix_t r;
    longint x, y, z, w, n;
    x = qx; y = qy; z = qz; w = qw;
    if (x == 0 && y == 0 && z == 0 && w == 0) begin
      // zero quaternion: identity, flagged
      foreach (r.m[i]) r.m[i] = (i % 4 == 0) ? comp_t'(longint'(1) << FB) : '0;
      r.degen = 1'b1;
      return r;
    end
    n = x*x + y*y + z*z + w*w;
    r.m[0] = ratio_to_entry(x*x + w*w - y*y - z*z, n);
    r.m[1] = ratio_to_entry(2*(x*y - w*z), n);
    r.m[2] = ratio_to_entry(2*(x*z + w*y), n);
    r.m[3] = ratio_to_entry(2*(x*y + w*z), n);
    r.m[4] = ratio_to_entry(y*y + w*w - x*x - z*z, n);
    r.m[5] = ratio_to_entry(2*(y*z - w*x), n);
    r.m[6] = ratio_to_entry(2*(x*z - w*y), n);
    r.m[7] = ratio_to_entry(2*(y*z + w*x), n);
    r.m[8] = ratio_to_entry(z*z + w*w - x*x - y*y, n);
    r.degen = 1'b0;
    return r;
  endfunction

  int mismatches;

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  class matrix_scoreboard;
    matrix_t pending[$];
    int requests, results, degen_seen;

    function void note_request(comp_t x, comp_t y, comp_t z, comp_t w);
      pending.push_back(rotation_of(x, y, z, w));
      requests++;
    endfunction

    task check_result(matrix_t got);
      matrix_t want;
      results++;
      if (pending.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.degen) degen_seen++;
      foreach (want.m[i])
        if (got.m[i] !== want.m[i])
          report_mismatch($sformatf("result %0d entry r%0d%0d: got %0d want %0d",
                          results, i / 3, i % 3, got.m[i], want.m[i]));
      if (got.degen !== want.degen)
        report_mismatch($sformatf("result %0d degenerate: got %b want %b",
                        results, got.degen, want.degen));
    endtask
  endclass

  logic clk, rst, start, busy, done, degenerate;
  comp_t quat_x, quat_y, quat_z, quat_w;
  comp_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

  quaternion_to_rotation_matrix #(.COMPONENT_WIDTH(CW)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .done(done),
    .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
    .r20(r20), .r21(r21), .r22(r22), .degenerate(degenerate)
  );

  matrix_scoreboard sb = new();
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result monitor and watchdog, both on the rising edge.
  always @(posedge clk) begin
    matrix_t got;
    if (!rst) begin
      if (done) begin
        got.m = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
        got.degen = degenerate;
        sb.check_result(got);
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Request driver: holds start until an edge takes it, then idles for the given gap.
  // start stays high across back-to-back requests, only the payload changes.
  task automatic send_request(comp_t x, comp_t y, comp_t z, comp_t w, int gap);
    start  <= 1'b1;
    quat_x <= x; quat_y <= y; quat_z <= z; quat_w <= w;
    do @(posedge clk); while (busy);
    sb.note_request(x, y, z, w);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 7) - 4);
      1: return $urandom_range(0, 1) ? comp_t'(1 << (CW - 1)) : comp_t'((1 << (CW - 1)) - 1);
      2: return comp_t'(longint'($urandom_range(0, 1 << (FB + 1))) - (1 << FB));
      default: return comp_t'($urandom());
    endcase
  endfunction

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  initial begin
    comp_t dx[$], dy[$], dz[$], dw[$];
    comp_t cmax, cmin, one;
    int gap;
    mismatches = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cmax = comp_t'((1 << (CW - 1)) - 1);
    cmin = comp_t'(1 << (CW - 1));
    one  = comp_t'(1 << FB);
    // Directed: zero quaternion, axis units, extremes, tiny norms, mixed signs.
    dx = '{0, one, 0, 0, 0, cmax, cmin, cmin, 1, 0, -1, cmax, cmin, one, 1, 0, 0};
    dy = '{0, 0, one, 0, 0, cmax, cmin, cmax, 0, 0, 1, cmin, cmax, one, 0, 1, 0};
    dz = '{0, 0, 0, one, 0, cmax, cmin, cmin, 0, 0, -1, cmax, 0, one, 0, 0, 1};
    dw = '{0, 0, 0, 0, one, cmax, cmin, cmax, 0, 1, 1, 0, cmin, one, 0, 0, 0};
    foreach (dx[i]) send_request(dx[i], dy[i], dz[i], dw[i], i % 3);
    // Sender holds off until the pipe is empty.
    start <= 1'b0;
    wait_drained();

    for (int i = 0; i < N_RANDOM; i++) begin
      // long stretches at full rate, the rest with random gaps
      gap = ((i / 200) % 2 == 0) ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0)
        send_request('0, '0, '0, '0, gap);
      else
        send_request(rand_comp(), rand_comp(), rand_comp(), rand_comp(), gap);
    end
    start <= 1'b0;
    wait_drained();

    $display("Covered %0d requests (%0d degenerate), %0d results checked.",
             sb.requests, sb.degen_seen, sb.results);
    if (mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired with %0d results outstanding.", sb.pending.size());
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/qrm_pkg.sv
hw/rtl/qrm_products.sv
hw/rtl/qrm_sums.sv
hw/rtl/qrm_div_stage.sv
hw/rtl/qrm_round.sv
hw/rtl/quaternion_to_rotation_matrix.sv
hw/rtl/qrm_checker.sv
tb/quaternion_to_rotation_matrix_tb.sv
